### rtl/zuc128_pkg.sv
// ZUC-128 shared package: S-boxes, D constants, command codes, controller
// types and the round helper functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package zuc128_pkg;

  localparam int unsigned NUM_CELLS   = 16;
  localparam int unsigned CELL_W      = 31;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned INIT_ROUNDS = 32;
  localparam int unsigned CNT_W       = $clog2(INIT_ROUNDS);
  localparam int unsigned CFG_W       = 64;
  localparam int unsigned CFG_ADDR_W  = 5;

  localparam logic [CELL_W-1:0] MASK31 = 31'h7FFF_FFFF;

  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_DATA    = 1'b1;

  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [1:0] REG_IV_HIGH  = 2'd2;
  localparam logic [1:0] REG_IV_LOW   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_WORK
  } state_t;

  typedef struct packed {
    logic load;
    logic round_init;
    logic round_work;
    logic gen;
  } dp_cmd_t;

  localparam logic [14:0] DCONST [NUM_CELLS] = '{
    15'h44D7, 15'h26BC, 15'h626B, 15'h135E, 15'h5789, 15'h35E2, 15'h7135, 15'h09AF,
    15'h4D78, 15'h2F13, 15'h6BC4, 15'h1AF1, 15'h5E26, 15'h3C4D, 15'h789A, 15'h47AC
  };

  localparam logic [7:0] SBOX0 [256] = '{
    8'h3e,8'h72,8'h5b,8'h47,8'hca,8'he0,8'h00,8'h33,8'h04,8'hd1,8'h54,8'h98,8'h09,8'hb9,8'h6d,8'hcb,
    8'h7b,8'h1b,8'hf9,8'h32,8'haf,8'h9d,8'h6a,8'ha5,8'hb8,8'h2d,8'hfc,8'h1d,8'h08,8'h53,8'h03,8'h90,
    8'h4d,8'h4e,8'h84,8'h99,8'he4,8'hce,8'hd9,8'h91,8'hdd,8'hb6,8'h85,8'h48,8'h8b,8'h29,8'h6e,8'hac,
    8'hcd,8'hc1,8'hf8,8'h1e,8'h73,8'h43,8'h69,8'hc6,8'hb5,8'hbd,8'hfd,8'h39,8'h63,8'h20,8'hd4,8'h38,
    8'h76,8'h7d,8'hb2,8'ha7,8'hcf,8'hed,8'h57,8'hc5,8'hf3,8'h2c,8'hbb,8'h14,8'h21,8'h06,8'h55,8'h9b,
    8'he3,8'hef,8'h5e,8'h31,8'h4f,8'h7f,8'h5a,8'ha4,8'h0d,8'h82,8'h51,8'h49,8'h5f,8'hba,8'h58,8'h1c,
    8'h4a,8'h16,8'hd5,8'h17,8'ha8,8'h92,8'h24,8'h1f,8'h8c,8'hff,8'hd8,8'hae,8'h2e,8'h01,8'hd3,8'had,
    8'h3b,8'h4b,8'hda,8'h46,8'heb,8'hc9,8'hde,8'h9a,8'h8f,8'h87,8'hd7,8'h3a,8'h80,8'h6f,8'h2f,8'hc8,
    8'hb1,8'hb4,8'h37,8'hf7,8'h0a,8'h22,8'h13,8'h28,8'h7c,8'hcc,8'h3c,8'h89,8'hc7,8'hc3,8'h96,8'h56,
    8'h07,8'hbf,8'h7e,8'hf0,8'h0b,8'h2b,8'h97,8'h52,8'h35,8'h41,8'h79,8'h61,8'ha6,8'h4c,8'h10,8'hfe,
    8'hbc,8'h26,8'h95,8'h88,8'h8a,8'hb0,8'ha3,8'hfb,8'hc0,8'h18,8'h94,8'hf2,8'he1,8'he5,8'he9,8'h5d,
    8'hd0,8'hdc,8'h11,8'h66,8'h64,8'h5c,8'hec,8'h59,8'h42,8'h75,8'h12,8'hf5,8'h74,8'h9c,8'haa,8'h23,
    8'h0e,8'h86,8'hab,8'hbe,8'h2a,8'h02,8'he7,8'h67,8'he6,8'h44,8'ha2,8'h6c,8'hc2,8'h93,8'h9f,8'hf1,
    8'hf6,8'hfa,8'h36,8'hd2,8'h50,8'h68,8'h9e,8'h62,8'h71,8'h15,8'h3d,8'hd6,8'h40,8'hc4,8'he2,8'h0f,
    8'h8e,8'h83,8'h77,8'h6b,8'h25,8'h05,8'h3f,8'h0c,8'h30,8'hea,8'h70,8'hb7,8'ha1,8'he8,8'ha9,8'h65,
    8'h8d,8'h27,8'h1a,8'hdb,8'h81,8'hb3,8'ha0,8'hf4,8'h45,8'h7a,8'h19,8'hdf,8'hee,8'h78,8'h34,8'h60
  };

  localparam logic [7:0] SBOX1 [256] = '{
    8'h55,8'hc2,8'h63,8'h71,8'h3b,8'hc8,8'h47,8'h86,8'h9f,8'h3c,8'hda,8'h5b,8'h29,8'haa,8'hfd,8'h77,
    8'h8c,8'hc5,8'h94,8'h0c,8'ha6,8'h1a,8'h13,8'h00,8'he3,8'ha8,8'h16,8'h72,8'h40,8'hf9,8'hf8,8'h42,
    8'h44,8'h26,8'h68,8'h96,8'h81,8'hd9,8'h45,8'h3e,8'h10,8'h76,8'hc6,8'ha7,8'h8b,8'h39,8'h43,8'he1,
    8'h3a,8'hb5,8'h56,8'h2a,8'hc0,8'h6d,8'hb3,8'h05,8'h22,8'h66,8'hbf,8'hdc,8'h0b,8'hfa,8'h62,8'h48,
    8'hdd,8'h20,8'h11,8'h06,8'h36,8'hc9,8'hc1,8'hcf,8'hf6,8'h27,8'h52,8'hbb,8'h69,8'hf5,8'hd4,8'h87,
    8'h7f,8'h84,8'h4c,8'hd2,8'h9c,8'h57,8'ha4,8'hbc,8'h4f,8'h9a,8'hdf,8'hfe,8'hd6,8'h8d,8'h7a,8'heb,
    8'h2b,8'h53,8'hd8,8'h5c,8'ha1,8'h14,8'h17,8'hfb,8'h23,8'hd5,8'h7d,8'h30,8'h67,8'h73,8'h08,8'h09,
    8'hee,8'hb7,8'h70,8'h3f,8'h61,8'hb2,8'h19,8'h8e,8'h4e,8'he5,8'h4b,8'h93,8'h8f,8'h5d,8'hdb,8'ha9,
    8'had,8'hf1,8'hae,8'h2e,8'hcb,8'h0d,8'hfc,8'hf4,8'h2d,8'h46,8'h6e,8'h1d,8'h97,8'he8,8'hd1,8'he9,
    8'h4d,8'h37,8'ha5,8'h75,8'h5e,8'h83,8'h9e,8'hab,8'h82,8'h9d,8'hb9,8'h1c,8'he0,8'hcd,8'h49,8'h89,
    8'h01,8'hb6,8'hbd,8'h58,8'h24,8'ha2,8'h5f,8'h38,8'h78,8'h99,8'h15,8'h90,8'h50,8'hb8,8'h95,8'he4,
    8'hd0,8'h91,8'hc7,8'hce,8'hed,8'h0f,8'hb4,8'h6f,8'ha0,8'hcc,8'hf0,8'h02,8'h4a,8'h79,8'hc3,8'hde,
    8'ha3,8'hef,8'hea,8'h51,8'he6,8'h6b,8'h18,8'hec,8'h1b,8'h2c,8'h80,8'hf7,8'h74,8'he7,8'hff,8'h21,
    8'h5a,8'h6a,8'h54,8'h1e,8'h41,8'h31,8'h92,8'h35,8'hc4,8'h33,8'h07,8'h0a,8'hba,8'h7e,8'h0e,8'h34,
    8'h88,8'hb1,8'h98,8'h7c,8'hf3,8'h3d,8'h60,8'h6c,8'h7b,8'hca,8'hd3,8'h1f,8'h32,8'h65,8'h04,8'h28,
    8'h64,8'hbe,8'h85,8'h9b,8'h2f,8'h59,8'h8a,8'hd7,8'hb0,8'h25,8'hac,8'haf,8'h12,8'h03,8'he2,8'hf2
  };

  function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                               input int unsigned k);
    return (x << k) | (x >> (WORD_W - k));
  endfunction

  function automatic logic [CELL_W-1:0] rotl31(input logic [CELL_W-1:0] x,
                                               input int unsigned k);
    return (x << k) | (x >> (CELL_W - k));
  endfunction

  function automatic logic [CELL_W-1:0] mod_add(input logic [CELL_W-1:0] a,
                                                input logic [CELL_W-1:0] b);
    logic [CELL_W:0] c;
    c = {1'b0, a} + {1'b0, b};
    return c[CELL_W-1:0] + CELL_W'(c[CELL_W]);
  endfunction

  function automatic logic [WORD_W-1:0] lin1(input logic [WORD_W-1:0] x);
    return x ^ rotl32(x, 2) ^ rotl32(x, 10) ^ rotl32(x, 18) ^ rotl32(x, 24);
  endfunction

  function automatic logic [WORD_W-1:0] lin2(input logic [WORD_W-1:0] x);
    return x ^ rotl32(x, 8) ^ rotl32(x, 14) ^ rotl32(x, 22) ^ rotl32(x, 30);
  endfunction

  function automatic logic [WORD_W-1:0] sbox_layer(input logic [WORD_W-1:0] x);
    return {SBOX0[x[31:24]], SBOX1[x[23:16]], SBOX0[x[15:8]], SBOX1[x[7:0]]};
  endfunction

endpackage
`default_nettype wire

### rtl/zuc128_in_if.sv
// Input channel of the ZUC-128 core: valid/ready plus command and data byte.
// Stand-alone interface, no dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface zuc128_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface
`default_nettype wire

### rtl/zuc128_out_if.sv
// Result channel of the ZUC-128 core: valid/ready plus the output byte.
// Stand-alone interface, no dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface zuc128_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface
`default_nettype wire

### rtl/zuc128_ctrl.sv
// ZUC-128 controller: input/output handshake, restart sequencing
// (32 init rounds and one work round). Depends on zuc128_pkg.
`timescale 1ns / 1ps
`default_nettype none
module zuc128_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_command,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output zuc128_pkg::dp_cmd_t     dp_cmd
);

  zuc128_pkg::state_t                state_r, state_nxt;
  logic [zuc128_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic                              in_acc;

  assign in_ready  = (state_r == zuc128_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= zuc128_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    dp_cmd        = '0;
    unique case (state_r)
      zuc128_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_command == zuc128_pkg::CMD_RESTART) begin
            dp_cmd.load = 1'b1;
            cnt_nxt     = '0;
            state_nxt   = zuc128_pkg::ST_INIT;
          end else begin
            dp_cmd.gen    = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end
      end
      zuc128_pkg::ST_INIT: begin
        dp_cmd.round_init = 1'b1;
        cnt_nxt           = cnt_r + 1'b1;
        if (cnt_r == zuc128_pkg::CNT_W'(zuc128_pkg::INIT_ROUNDS - 1)) begin
          state_nxt = zuc128_pkg::ST_WORK;
        end
      end
      zuc128_pkg::ST_WORK: begin
        dp_cmd.round_work = 1'b1;
        state_nxt         = zuc128_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = zuc128_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/zuc128_dp.sv
// ZUC-128 datapath: LFSR cells, bit reorganization, nonlinear F, keystream
// word, byte position and output byte register. Depends on zuc128_pkg.
`timescale 1ns / 1ps
`default_nettype none
module zuc128_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire zuc128_pkg::dp_cmd_t           dp_cmd,
  input  wire logic [zuc128_pkg::CFG_W-1:0]  key_high,
  input  wire logic [zuc128_pkg::CFG_W-1:0]  key_low,
  input  wire logic [zuc128_pkg::CFG_W-1:0]  iv_high,
  input  wire logic [zuc128_pkg::CFG_W-1:0]  iv_low,
  input  wire logic [7:0]                    data_byte,
  output logic [7:0]                         out_byte
);

  localparam int unsigned CW = zuc128_pkg::CELL_W;
  localparam int unsigned WW = zuc128_pkg::WORD_W;
  localparam int unsigned NC = zuc128_pkg::NUM_CELLS;

  logic [CW-1:0] lfsr_r [NC];
  logic [CW-1:0] lfsr_nxt [NC];
  logic [CW-1:0] load_cell [NC];
  logic [WW-1:0] r1_r, r1_nxt, r2_r, r2_nxt, ks_r, ks_nxt;
  logic [1:0]    pos_r, pos_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;

  logic [WW-1:0] x0, x1, x2, x3, w, w1, w2, ua, ub, r1_new, r2_new, ks_cur;
  logic [CW-1:0] extra, s0, s1, s2, fb, fb_fix;
  logic [1:0]    sel;
  logic          step;

  assign out_byte = out_byte_r;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      load_cell[i]     = {key_high[63-8*i -: 8], zuc128_pkg::DCONST[i],
                          iv_high[63-8*i -: 8]};
      load_cell[i + 8] = {key_low[63-8*i -: 8], zuc128_pkg::DCONST[i + 8],
                          iv_low[63-8*i -: 8]};
    end
  end

  // bit reorganization and F
  assign x0 = {lfsr_r[15][30:15], lfsr_r[14][15:0]};
  assign x1 = {lfsr_r[11][15:0], lfsr_r[9][30:15]};
  assign x2 = {lfsr_r[7][15:0], lfsr_r[5][30:15]};
  assign x3 = {lfsr_r[2][15:0], lfsr_r[0][30:15]};

  assign w      = (x0 ^ r1_r) + r2_r;
  assign w1     = r1_r + x1;
  assign w2     = r2_r ^ x2;
  assign ua     = {w1[15:0], w2[31:16]};
  assign ub     = {w2[15:0], w1[31:16]};
  assign r1_new = zuc128_pkg::sbox_layer(zuc128_pkg::lin1(ua));
  assign r2_new = zuc128_pkg::sbox_layer(zuc128_pkg::lin2(ub));

  // LFSR feedback, adder tree mod 2^31-1
  assign extra  = dp_cmd.round_init ? w[WW-1:1] : '0;
  assign s0     = zuc128_pkg::mod_add(lfsr_r[0], zuc128_pkg::rotl31(lfsr_r[0], 8));
  assign s1     = zuc128_pkg::mod_add(zuc128_pkg::rotl31(lfsr_r[4], 20),
                                      zuc128_pkg::rotl31(lfsr_r[10], 21));
  assign s2     = zuc128_pkg::mod_add(zuc128_pkg::rotl31(lfsr_r[13], 17),
                                      zuc128_pkg::rotl31(lfsr_r[15], 15));
  assign fb     = zuc128_pkg::mod_add(zuc128_pkg::mod_add(s0, s1),
                                      zuc128_pkg::mod_add(s2, extra));
  assign fb_fix = (fb == '0) ? zuc128_pkg::MASK31 : fb;

  assign step   = dp_cmd.round_init || dp_cmd.round_work || (dp_cmd.gen && (pos_r == 2'd0));
  assign ks_cur = (pos_r == 2'd0) ? (w ^ x3) : ks_r;
  assign sel    = 2'd3 - pos_r;

  always_comb begin
    lfsr_nxt     = lfsr_r;
    r1_nxt       = r1_r;
    r2_nxt       = r2_r;
    ks_nxt       = ks_r;
    pos_nxt      = pos_r;
    out_byte_nxt = out_byte_r;
    priority if (dp_cmd.load) begin
      lfsr_nxt = load_cell;
      r1_nxt   = '0;
      r2_nxt   = '0;
      ks_nxt   = '0;
      pos_nxt  = '0;
    end else if (step) begin
      for (int i = 0; i < NC - 1; i++) begin
        lfsr_nxt[i] = lfsr_r[i + 1];
      end
      lfsr_nxt[NC-1] = fb_fix;
      r1_nxt         = r1_new;
      r2_nxt         = r2_new;
      if (dp_cmd.gen) begin
        ks_nxt = ks_cur;
      end
    end
    if (dp_cmd.gen) begin
      pos_nxt      = pos_r + 2'd1;
      out_byte_nxt = data_byte ^ 8'(ks_cur >> {sel, 3'b000});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NC; i++) begin
        lfsr_r[i] <= '0;
      end
      r1_r  <= '0;
      r2_r  <= '0;
      ks_r  <= '0;
      pos_r <= '0;
    end else begin
      lfsr_r <= lfsr_nxt;
      r1_r   <= r1_nxt;
      r2_r   <= r2_nxt;
      ks_r   <= ks_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
  end

endmodule
`default_nettype wire

### rtl/zuc128_stream_cipher_core.sv
// ZUC-128 stream cipher top level: APB-style key/IV registers, controller and
// datapath. Depends on zuc128_pkg, zuc128_in_if, zuc128_out_if, zuc128_ctrl, zuc128_dp.
//
// A data item (command 1) is taken every cycle while the output register is
// free or being drained; its result byte appears in the cycle after acceptance.
// A restart item (command 0) occupies the single LFSR/F round unit with a load,
// 32 initialization rounds and one discarded work round; in_ch.ready is low
// during the rounds. Key and IV are sampled at the restart.
// Registers are 64 bits at byte addresses 0, 8, 16, 24 (key high/low, IV
// high/low); paddr[2:0] is not decoded.
`timescale 1ns / 1ps
`default_nettype none
module zuc128_stream_cipher_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  zuc128_in_if.sink                               in_ch,
  zuc128_out_if.source                            out_ch,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [zuc128_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [zuc128_pkg::CFG_W-1:0]       pwdata,
  output logic [zuc128_pkg::CFG_W-1:0]            prdata,
  output logic                                    pready
);

  logic [zuc128_pkg::CFG_W-1:0] key_high_r, key_low_r, iv_high_r, iv_low_r;
  logic [1:0]                   reg_idx;
  logic                         cfg_wr;
  zuc128_pkg::dp_cmd_t          dp_cmd;

  assign pready  = 1'b1;
  assign reg_idx = paddr[zuc128_pkg::CFG_ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      iv_high_r  <= '0;
      iv_low_r   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        zuc128_pkg::REG_KEY_HIGH: key_high_r <= pwdata;
        zuc128_pkg::REG_KEY_LOW:  key_low_r  <= pwdata;
        zuc128_pkg::REG_IV_HIGH:  iv_high_r  <= pwdata;
        zuc128_pkg::REG_IV_LOW:   iv_low_r   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      zuc128_pkg::REG_KEY_HIGH: prdata = key_high_r;
      zuc128_pkg::REG_KEY_LOW:  prdata = key_low_r;
      zuc128_pkg::REG_IV_HIGH:  prdata = iv_high_r;
      zuc128_pkg::REG_IV_LOW:   prdata = iv_low_r;
      default:                  prdata = '0;
    endcase
  end

  zuc128_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .dp_cmd     (dp_cmd)
  );

  zuc128_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .dp_cmd    (dp_cmd),
    .key_high  (key_high_r),
    .key_low   (key_low_r),
    .iv_high   (iv_high_r),
    .iv_low    (iv_low_r),
    .data_byte (in_ch.data_byte),
    .out_byte  (out_ch.out_byte)
  );

endmodule
`default_nettype wire

### sim/tb_zuc128_stream_cipher_core.sv
// Testbench for zuc128_stream_cipher_core: key/IV registers over APB, restart and
// data items on the input channel, output bytes checked against a ZUC keystream
// predictor. Depends on zuc128_pkg, zuc128_in_if, zuc128_out_if and the core.
`timescale 1ns / 1ps
module tb_zuc128_stream_cipher_core;

  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 150;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned PHASES        = 12;
  localparam int unsigned PHASE_ITEMS   = 70;

  localparam logic [7:0] S0_TBL [256] = '{
    'h3e,'h72,'h5b,'h47,'hca,'he0,'h00,'h33,'h04,'hd1,'h54,'h98,'h09,'hb9,'h6d,'hcb,
    'h7b,'h1b,'hf9,'h32,'haf,'h9d,'h6a,'ha5,'hb8,'h2d,'hfc,'h1d,'h08,'h53,'h03,'h90,
    'h4d,'h4e,'h84,'h99,'he4,'hce,'hd9,'h91,'hdd,'hb6,'h85,'h48,'h8b,'h29,'h6e,'hac,
    'hcd,'hc1,'hf8,'h1e,'h73,'h43,'h69,'hc6,'hb5,'hbd,'hfd,'h39,'h63,'h20,'hd4,'h38,
    'h76,'h7d,'hb2,'ha7,'hcf,'hed,'h57,'hc5,'hf3,'h2c,'hbb,'h14,'h21,'h06,'h55,'h9b,
    'he3,'hef,'h5e,'h31,'h4f,'h7f,'h5a,'ha4,'h0d,'h82,'h51,'h49,'h5f,'hba,'h58,'h1c,
    'h4a,'h16,'hd5,'h17,'ha8,'h92,'h24,'h1f,'h8c,'hff,'hd8,'hae,'h2e,'h01,'hd3,'had,
    'h3b,'h4b,'hda,'h46,'heb,'hc9,'hde,'h9a,'h8f,'h87,'hd7,'h3a,'h80,'h6f,'h2f,'hc8,
    'hb1,'hb4,'h37,'hf7,'h0a,'h22,'h13,'h28,'h7c,'hcc,'h3c,'h89,'hc7,'hc3,'h96,'h56,
    'h07,'hbf,'h7e,'hf0,'h0b,'h2b,'h97,'h52,'h35,'h41,'h79,'h61,'ha6,'h4c,'h10,'hfe,
    'hbc,'h26,'h95,'h88,'h8a,'hb0,'ha3,'hfb,'hc0,'h18,'h94,'hf2,'he1,'he5,'he9,'h5d,
    'hd0,'hdc,'h11,'h66,'h64,'h5c,'hec,'h59,'h42,'h75,'h12,'hf5,'h74,'h9c,'haa,'h23,
    'h0e,'h86,'hab,'hbe,'h2a,'h02,'he7,'h67,'he6,'h44,'ha2,'h6c,'hc2,'h93,'h9f,'hf1,
    'hf6,'hfa,'h36,'hd2,'h50,'h68,'h9e,'h62,'h71,'h15,'h3d,'hd6,'h40,'hc4,'he2,'h0f,
    'h8e,'h83,'h77,'h6b,'h25,'h05,'h3f,'h0c,'h30,'hea,'h70,'hb7,'ha1,'he8,'ha9,'h65,
    'h8d,'h27,'h1a,'hdb,'h81,'hb3,'ha0,'hf4,'h45,'h7a,'h19,'hdf,'hee,'h78,'h34,'h60
  };

  localparam logic [7:0] S1_TBL [256] = '{
    'h55,'hc2,'h63,'h71,'h3b,'hc8,'h47,'h86,'h9f,'h3c,'hda,'h5b,'h29,'haa,'hfd,'h77,
    'h8c,'hc5,'h94,'h0c,'ha6,'h1a,'h13,'h00,'he3,'ha8,'h16,'h72,'h40,'hf9,'hf8,'h42,
    'h44,'h26,'h68,'h96,'h81,'hd9,'h45,'h3e,'h10,'h76,'hc6,'ha7,'h8b,'h39,'h43,'he1,
    'h3a,'hb5,'h56,'h2a,'hc0,'h6d,'hb3,'h05,'h22,'h66,'hbf,'hdc,'h0b,'hfa,'h62,'h48,
    'hdd,'h20,'h11,'h06,'h36,'hc9,'hc1,'hcf,'hf6,'h27,'h52,'hbb,'h69,'hf5,'hd4,'h87,
    'h7f,'h84,'h4c,'hd2,'h9c,'h57,'ha4,'hbc,'h4f,'h9a,'hdf,'hfe,'hd6,'h8d,'h7a,'heb,
    'h2b,'h53,'hd8,'h5c,'ha1,'h14,'h17,'hfb,'h23,'hd5,'h7d,'h30,'h67,'h73,'h08,'h09,
    'hee,'hb7,'h70,'h3f,'h61,'hb2,'h19,'h8e,'h4e,'he5,'h4b,'h93,'h8f,'h5d,'hdb,'ha9,
    'had,'hf1,'hae,'h2e,'hcb,'h0d,'hfc,'hf4,'h2d,'h46,'h6e,'h1d,'h97,'he8,'hd1,'he9,
    'h4d,'h37,'ha5,'h75,'h5e,'h83,'h9e,'hab,'h82,'h9d,'hb9,'h1c,'he0,'hcd,'h49,'h89,
    'h01,'hb6,'hbd,'h58,'h24,'ha2,'h5f,'h38,'h78,'h99,'h15,'h90,'h50,'hb8,'h95,'he4,
    'hd0,'h91,'hc7,'hce,'hed,'h0f,'hb4,'h6f,'ha0,'hcc,'hf0,'h02,'h4a,'h79,'hc3,'hde,
    'ha3,'hef,'hea,'h51,'he6,'h6b,'h18,'hec,'h1b,'h2c,'h80,'hf7,'h74,'he7,'hff,'h21,
    'h5a,'h6a,'h54,'h1e,'h41,'h31,'h92,'h35,'hc4,'h33,'h07,'h0a,'hba,'h7e,'h0e,'h34,
    'h88,'hb1,'h98,'h7c,'hf3,'h3d,'h60,'h6c,'h7b,'hca,'hd3,'h1f,'h32,'h65,'h04,'h28,
    'h64,'hbe,'h85,'h9b,'h2f,'h59,'h8a,'hd7,'hb0,'h25,'hac,'haf,'h12,'h03,'he2,'hf2
  };

  localparam logic [14:0] D_TBL [16] = '{
    'h44D7, 'h26BC, 'h626B, 'h135E, 'h5789, 'h35E2, 'h7135, 'h09AF,
    'h4D78, 'h2F13, 'h6BC4, 'h1AF1, 'h5E26, 'h3C4D, 'h789A, 'h47AC
  };

  class keystream_scoreboard;
    logic [63:0] cfg_regs [4];
    logic [30:0] cells [16];
    logic [31:0] r1, r2, kword, x0, x1, x2, x3;
    logic [1:0]  bpos;
    logic [7:0]  expected_bytes [$];
    int unsigned errors;

    function new();
      foreach (cfg_regs[i]) cfg_regs[i] = '0;
      foreach (cells[i]) cells[i] = '0;
      r1 = '0; r2 = '0; kword = '0; bpos = '0;
      x0 = '0; x1 = '0; x2 = '0; x3 = '0;
      errors = 0;
    endfunction

    function logic [30:0] add31(logic [30:0] a, logic [30:0] b);
      logic [31:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[30:0] + {30'd0, s[31]};
    endfunction

    function logic [30:0] rot31(logic [30:0] v, int k);
      return (v << k) | (v >> (31 - k));
    endfunction

    function logic [31:0] rot32(logic [31:0] v, int k);
      return (v << k) | (v >> (32 - k));
    endfunction

    function logic [31:0] subst(logic [31:0] v);
      return {S0_TBL[v[31:24]], S1_TBL[v[23:16]], S0_TBL[v[15:8]], S1_TBL[v[7:0]]};
    endfunction

    function void reorganize();
      x0 = {cells[15][30:15], cells[14][15:0]};
      x1 = {cells[11][15:0], cells[9][30:15]};
      x2 = {cells[7][15:0], cells[5][30:15]};
      x3 = {cells[2][15:0], cells[0][30:15]};
    endfunction

    function logic [31:0] f_round();
      logic [31:0] w, w1, w2, u, v;
      w  = (x0 ^ r1) + r2;
      w1 = r1 + x1;
      w2 = r2 ^ x2;
      u  = {w1[15:0], w2[31:16]};
      v  = {w2[15:0], w1[31:16]};
      u  = u ^ rot32(u, 2) ^ rot32(u, 10) ^ rot32(u, 18) ^ rot32(u, 24);
      v  = v ^ rot32(v, 8) ^ rot32(v, 14) ^ rot32(v, 22) ^ rot32(v, 30);
      r1 = subst(u);
      r2 = subst(v);
      return w;
    endfunction

    function void lfsr_shift(logic [30:0] extra);
      logic [30:0] fb;
      fb = add31(cells[0], rot31(cells[0], 8));
      fb = add31(fb, rot31(cells[4], 20));
      fb = add31(fb, rot31(cells[10], 21));
      fb = add31(fb, rot31(cells[13], 17));
      fb = add31(fb, rot31(cells[15], 15));
      fb = add31(fb, extra);
      // a zero sum is stored as 2^31-1
      if (fb == '0) fb = zuc128_pkg::MASK31;
      for (int i = 0; i < 15; i++) cells[i] = cells[i + 1];
      cells[15] = fb;
    endfunction

    function void restart();
      logic [127:0] key, iv;
      logic [31:0]  w;
      key = {cfg_regs[zuc128_pkg::REG_KEY_HIGH], cfg_regs[zuc128_pkg::REG_KEY_LOW]};
      iv  = {cfg_regs[zuc128_pkg::REG_IV_HIGH], cfg_regs[zuc128_pkg::REG_IV_LOW]};
      for (int i = 0; i < 16; i++)
        cells[i] = {key[127 - 8 * i -: 8], D_TBL[i], iv[127 - 8 * i -: 8]};
      r1 = '0;
      r2 = '0;
      for (int i = 0; i < 32; i++) begin
        reorganize();
        w = f_round();
        lfsr_shift(w[31:1]);
      end
      reorganize();
      void'(f_round());
      lfsr_shift('0);
      kword = '0;
      bpos  = '0;
    endfunction

    function void note_input(logic cmd, logic [7:0] d);
      if (cmd == zuc128_pkg::CMD_RESTART) begin
        restart();
      end else begin
        if (bpos == 2'd0) begin
          reorganize();
          kword = f_round() ^ x3;
          lfsr_shift('0);
        end
        expected_bytes.push_back(d ^ kword[31 - 8 * bpos -: 8]);
        bpos = bpos + 2'd1;
      end
    endfunction

    task report(string msg);
      errors++;
      $display("%0t ns: %s", $time, msg);
    endtask

    task check_result(logic [7:0] got);
      logic [7:0] want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("out_byte %02h with no item pending", got));
      end else begin
        want = expected_bytes.pop_front();
        if (got !== want) report($sformatf("out_byte %02h, expected %02h", got, want));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [zuc128_pkg::CFG_ADDR_W-1:0] paddr;
  logic [zuc128_pkg::CFG_W-1:0]      pwdata, prdata;

  zuc128_in_if  in_bus ();
  zuc128_out_if out_bus ();

  keystream_scoreboard sb = new();

  int unsigned idle_pct;
  int unsigned hold_req, hold_seen, hold_left;
  int unsigned quiet_cycles;

  zuc128_stream_cipher_core i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) sb.check_result(out_bus.out_byte);
      if (in_bus.valid && in_bus.ready) sb.note_input(in_bus.command, in_bus.data_byte);
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] d);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid     <= 1'b0;
      in_bus.command   <= 1'($urandom);
      in_bus.data_byte <= 8'($urandom);
      @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.command   <= cmd;
    in_bus.data_byte <= d;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // block idle: nothing offered, every byte back, restart rounds finished
  task automatic settle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write one register, then read it back
  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.cfg_regs[idx] = v;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== v)
      sb.report($sformatf("register %0d reads %016h, expected %016h", idx, prdata, v));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_key_iv(input logic [63:0] kh, input logic [63:0] kl,
                             input logic [63:0] ih, input logic [63:0] il);
    cfg_write(zuc128_pkg::REG_KEY_HIGH, kh);
    cfg_write(zuc128_pkg::REG_KEY_LOW, kl);
    cfg_write(zuc128_pkg::REG_IV_HIGH, ih);
    cfg_write(zuc128_pkg::REG_IV_LOW, il);
  endtask

  initial begin
    logic [63:0] regv [4];
    int unsigned roll;
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.command   = zuc128_pkg::CMD_DATA;
    in_bus.data_byte = '0;
    out_bus.ready    = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    idle_pct         = 9;
    hold_req         = 0;
    hold_seen        = 0;
    hold_left        = 0;
    quiet_cycles     = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // keystream straight from the all-zero reset state
    send_item(zuc128_pkg::CMD_DATA, 8'h00);
    send_item(zuc128_pkg::CMD_DATA, 8'hFF);
    send_item(zuc128_pkg::CMD_DATA, 8'h5A);
    send_item(zuc128_pkg::CMD_DATA, 8'hA5);
    send_item(zuc128_pkg::CMD_DATA, 8'h3C);
    settle();

    load_key_iv('0, '0, '0, '0);
    send_item(zuc128_pkg::CMD_RESTART, 8'hFF);
    repeat (8) send_item(zuc128_pkg::CMD_DATA, 8'h00);
    settle();

    load_key_iv('1, '1, '1, '1);
    send_item(zuc128_pkg::CMD_RESTART, 8'h00);
    send_item(zuc128_pkg::CMD_DATA, 8'hFF);
    send_item(zuc128_pkg::CMD_DATA, 8'hFF);
    send_item(zuc128_pkg::CMD_DATA, 8'h0F);
    // restart in the middle of a word
    send_item(zuc128_pkg::CMD_RESTART, 8'h00);
    send_item(zuc128_pkg::CMD_DATA, 8'h80);
    send_item(zuc128_pkg::CMD_DATA, 8'h01);
    settle();

    // key change takes effect only at the next restart
    cfg_write(zuc128_pkg::REG_KEY_HIGH, {$urandom, $urandom});
    send_item(zuc128_pkg::CMD_DATA, 8'h55);
    send_item(zuc128_pkg::CMD_DATA, 8'hAA);
    send_item(zuc128_pkg::CMD_RESTART, 8'h00);
    send_item(zuc128_pkg::CMD_DATA, 8'h00);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      foreach (regv[i]) begin
        roll = $urandom_range(4);
        regv[i] = (roll == 0) ? 64'd0 : (roll == 1) ? '1 : {$urandom, $urandom};
      end
      load_key_iv(regv[0], regv[1], regv[2], regv[3]);
      idle_pct = (ph == 3) ? 0 : 9;
      send_item(zuc128_pkg::CMD_RESTART, 8'($urandom));
      if (ph == 6) hold_req++;
      for (int n = 1; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 4) send_item(zuc128_pkg::CMD_RESTART, 8'($urandom));
        else send_item(zuc128_pkg::CMD_DATA, 8'($urandom_range(255)));
      end
      settle();
    end
    idle_pct = 9;

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
